// ===== rtl/plte_pkg.sv =====
// Shared types and constants for the piecewise-linear table evaluator.
// Item payloads, function and status codes, controller states and the
// command/status bundles between controller and datapath.
package plte_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int TIME_W          = 32;
    localparam int AMP_W           = 16;
    localparam int COUNT_W         = 11;
    localparam int MAG_W           = AMP_W + 1;
    localparam int PROD_W          = MAG_W + TIME_W;
    localparam int DIV_STEPS       = MAG_W;
    localparam int STEP_W          = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        FN_APPEND = 2'd0,
        FN_EVAL   = 2'd1,
        FN_CLEAR  = 2'd2,
        FN_NONE   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_ORDER = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]               func;
        logic [TIME_W-1:0]        point_time;
        logic signed [AMP_W-1:0]  point_amplitude;
    } t_in_item;

    typedef struct packed {
        logic signed [AMP_W-1:0]  amplitude;
        logic [1:0]               status;
        logic [COUNT_W-1:0]       point_count;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_RD_HI,
        S_CAP_HI,
        S_MUL,
        S_DIV,
        S_ADJ,
        S_FINISH
    } t_state;

    typedef enum logic [1:0] {
        RD_MID = 2'd0,
        RD_LO  = 2'd1,
        RD_HI  = 2'd2
    } t_rd_sel;

    typedef struct packed {
        logic    load;
        logic    exec;
        logic    srch_upd;
        t_rd_sel rd_sel;
        logic    cap_lo;
        logic    cap_hi;
        logic    mul;
        logic    div_step;
        logic    adj;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        t_func func;
        logic  in_range;
        logic  narrow;
        logic  div_last;
    } t_sts;

endpackage

// ===== rtl/plte_dpath.sv =====
// Datapath of the piecewise-linear table evaluator: point memories, search
// bounds, multiplier, restoring divider and result register. Uses plte_pkg.
module plte_dpath
    import plte_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in_data,
    input  t_cmd      i_cmd,
    output t_sts      o_sts,
    output t_out_item o_out_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [TIME_W-1:0] time_mem [TABLE_DEPTH];
    logic [AMP_W-1:0]  amp_mem  [TABLE_DEPTH];

    t_func                   r_func;
    logic [TIME_W-1:0]       r_t;
    logic [AMP_W-1:0]        r_amp_in;
    logic [CW-1:0]           r_count;
    logic [TIME_W-1:0]       r_first_time;
    logic [TIME_W-1:0]       r_last_time;
    logic [AW-1:0]           r_lo;
    logic [AW-1:0]           r_hi;
    logic [TIME_W-1:0]       r_t_rd;
    logic [AMP_W-1:0]        r_a_rd;
    logic [TIME_W-1:0]       r_tl;
    logic [AMP_W-1:0]        r_al;
    logic [TIME_W-1:0]       r_dt;
    logic [TIME_W-1:0]       r_den;
    logic [MAG_W-1:0]        r_mag;
    logic                    r_neg;
    logic                    r_eq;
    logic [TIME_W-1:0]       r_rem;
    logic [MAG_W-1:0]        r_num;
    logic [STEP_W-1:0]       r_step;
    logic [AMP_W-1:0]        r_res_amp;
    t_status                 r_res_status;
    t_out_item               r_out_data;

    logic [AW:0]       mid_w;
    logic [AW-1:0]     mid;
    logic [AW:0]       lo_p1;
    logic [CW-1:0]     cnt_m1;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic              full;
    logic              order_err;
    logic              in_range;
    logic              mem_we;
    logic [MAG_W-1:0]  diff;
    logic [PROD_W-1:0] prod;
    logic [TIME_W:0]   rem2;
    logic [TIME_W:0]   rem_sub;
    logic              ge;
    logic [MAG_W-1:0]  al_ext;
    logic [MAG_W-1:0]  adj_sum;

    always_comb begin
        mid_w    = ({1'b0, r_lo} + {1'b0, r_hi}) >> 1;
        mid      = mid_w[AW-1:0];
        lo_p1    = {1'b0, r_lo} + {{AW{1'b0}}, 1'b1};
        cnt_m1   = r_count - {{(CW-1){1'b0}}, 1'b1};
        wr_addr  = r_count[AW-1:0];
        full     = (r_count >= CW'(TABLE_DEPTH));
        order_err = (r_count != '0) && (r_t < r_last_time);
        in_range = (r_count != '0) && (r_t >= r_first_time) && (r_t <= r_last_time);
        mem_we   = i_cmd.exec && (r_func == FN_APPEND) && !full && !order_err;

        unique case (i_cmd.rd_sel)
            RD_MID:  rd_addr = mid;
            RD_LO:   rd_addr = r_lo;
            RD_HI:   rd_addr = r_hi;
            default: rd_addr = mid;
        endcase

        diff = {r_a_rd[AMP_W-1], r_a_rd} - {r_al[AMP_W-1], r_al};
        prod = PROD_W'(r_mag) * PROD_W'(r_dt);

        rem2    = {r_rem, r_num[MAG_W-1]};
        ge      = (rem2 >= {1'b0, r_den});
        rem_sub = rem2 - {1'b0, r_den};

        al_ext  = {r_al[AMP_W-1], r_al};
        adj_sum = r_neg ? (al_ext - r_num) : (al_ext + r_num);

        o_sts.func     = r_func;
        o_sts.in_range = in_range;
        o_sts.narrow   = (lo_p1 >= {1'b0, r_hi});
        o_sts.div_last = (r_step == '0);
    end

    // Point memories: one write port, one registered read port each.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            time_mem[wr_addr] <= r_t;
            amp_mem[wr_addr]  <= r_amp_in;
        end
        r_t_rd <= time_mem[rd_addr];
        r_a_rd <= amp_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            if (r_func == FN_CLEAR) begin
                r_count <= '0;
            end else if (mem_we) begin
                r_count <= r_count + {{(CW-1){1'b0}}, 1'b1};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func   <= t_func'(i_in_data.func);
            r_t      <= i_in_data.point_time;
            r_amp_in <= i_in_data.point_amplitude;
        end
        if (i_cmd.exec) begin
            r_lo      <= '0;
            r_hi      <= cnt_m1[AW-1:0];
            r_res_amp <= '0;
            if (mem_we) begin
                r_last_time <= r_t;
                if (r_count == '0) begin
                    r_first_time <= r_t;
                end
            end
            unique case (r_func)
                FN_APPEND: r_res_status <= full ? ST_FULL : (order_err ? ST_ORDER : ST_OK);
                FN_EVAL:   r_res_status <= in_range ? ST_OK : ST_RANGE;
                default:   r_res_status <= ST_OK;
            endcase
        end
        if (i_cmd.srch_upd) begin
            if (r_t <= r_t_rd) begin
                r_hi <= mid;
            end else begin
                r_lo <= mid;
            end
        end
        if (i_cmd.cap_lo) begin
            r_tl <= r_t_rd;
            r_al <= r_a_rd;
        end
        if (i_cmd.cap_hi) begin
            r_neg <= diff[MAG_W-1];
            r_mag <= diff[MAG_W-1] ? (~diff + {{(MAG_W-1){1'b0}}, 1'b1}) : diff;
            r_dt  <= r_t - r_tl;
            r_den <= r_t_rd - r_tl;
            r_eq  <= (r_t_rd == r_tl);
        end
        if (i_cmd.mul) begin
            r_rem  <= prod[PROD_W-1 -: TIME_W];
            r_num  <= prod[MAG_W-1:0];
            r_step <= STEP_W'(DIV_STEPS - 1);
        end
        if (i_cmd.div_step) begin
            r_rem  <= ge ? rem_sub[TIME_W-1:0] : rem2[TIME_W-1:0];
            r_num  <= {r_num[MAG_W-2:0], ge};
            r_step <= r_step - {{(STEP_W-1){1'b0}}, 1'b1};
        end
        if (i_cmd.adj) begin
            r_res_amp <= r_eq ? r_al : adj_sum[AMP_W-1:0];
        end
        if (i_cmd.out_load) begin
            r_out_data.amplitude   <= r_res_amp;
            r_out_data.status      <= r_res_status;
            r_out_data.point_count <= COUNT_W'(r_count);
        end
    end

    assign o_out_data = r_out_data;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("point count above table depth");

    a_search_bracket: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.srch_upd |=> (r_lo < r_hi))
        else $error("search bounds collapsed");

    a_append_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |=> (r_count == $past(r_count) + {{(CW-1){1'b0}}, 1'b1}))
        else $error("append did not advance count");

endmodule

// ===== rtl/plte_ctrl.sv =====
// Controller of the piecewise-linear table evaluator: sequences decode,
// search, interpolation and result transfer. Uses plte_pkg.
module plte_ctrl
    import plte_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        o_cmd       = '0;
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_in_ready  = (r_state == S_IDLE);

        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.exec = 1'b1;
                if (i_sts.func == FN_EVAL && i_sts.in_range) begin
                    n_state = S_SRCH_RD;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_SRCH_RD: begin
                if (i_sts.narrow) begin
                    o_cmd.rd_sel = RD_LO;
                    n_state      = S_RD_HI;
                end else begin
                    o_cmd.rd_sel = RD_MID;
                    n_state      = S_SRCH_CMP;
                end
            end
            S_SRCH_CMP: begin
                o_cmd.srch_upd = 1'b1;
                n_state        = S_SRCH_RD;
            end
            S_RD_HI: begin
                o_cmd.rd_sel = RD_HI;
                o_cmd.cap_lo = 1'b1;
                n_state      = S_CAP_HI;
            end
            S_CAP_HI: begin
                o_cmd.cap_hi = 1'b1;
                n_state      = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_ADJ;
                end
            end
            S_ADJ: begin
                o_cmd.adj = 1'b1;
                n_state   = S_FINISH;
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

    a_accept_decodes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_DECODE))
        else $error("accepted item not decoded");

    a_finish_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH && r_out_valid && !i_out_ready) |=>
            (r_state == S_FINISH && r_out_valid))
        else $error("result overwrote a stalled transfer");

    a_div_to_adj: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && i_sts.div_last) |=> (r_state == S_ADJ))
        else $error("divider did not finish");

endmodule

// ===== rtl/piecewise_linear_table_eval.sv =====
// Piecewise-linear table evaluator, top level.
// Input channel i_in_valid / o_in_ready / i_in_data carries one item per
// transfer: func selects append point, evaluate at time, clear table or no operation.
// Output channel o_out_valid / i_out_ready / o_out_data returns exactly one
// result per item: amplitude, status and the point count after the item.
// Items are processed one at a time. Append, clear and rejected or
// out-of-range items go from decode straight to the result register.
// An evaluation runs a binary search over the table, each step a read
// on the single read port of the time memory and a compare, then two
// reads for the bracketing pair, a multiply and a restoring divide for
// the interpolation fraction. The input is ready again in the cycle
// after a result is loaded. A finished result sits in the output register;
// the next item is accepted while it waits, and that item's result is held
// back until the receiver takes the pending one. Reset empties the table
// and drops any pending result; the point memories are not cleared, and
// entries are read only after they were written.
module piecewise_linear_table_eval
    import plte_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    // Command and status bundles between sequencer and datapath.
    t_cmd cmd;
    t_sts sts;

    // Sequencer: owns the state machine and the output valid flag.
    plte_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Datapath: point memories, search bounds, multiply/divide, result.
    plte_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out_data (o_out_data)
    );

endmodule
